// ===== design/cop_pkg.sv =====
// circle outline point generator: shared constants, types and tables
// no dependencies
package cop_pkg;

   localparam int AngleBitsDefault = 16;
   localparam int CoordBitsDefault = 12;
   localparam int IndexBits        = 16;
   localparam int RadiusBits       = 11;
   localparam int NumBits          = 16;
   localparam int OutBits          = 14;
   localparam int CordicSteps      = 24;
   localparam int DivSteps         = 4;
   localparam int CordicPerStage   = 4;
   localparam int CordicStages     = CordicSteps / CordicPerStage;
   localparam int CordicBits       = 33;
   localparam int ZBits            = 33;
   localparam int TrigBits         = 17;
   localparam logic [CordicBits-1:0] CordicGain = 33'd652032874;

   localparam int CsrAddrBits = 4;
   typedef enum logic [1:0] {
      REG_CENTER_X   = 2'd0,
      REG_CENTER_Y   = 2'd1,
      REG_RADIUS     = 2'd2,
      REG_NUM_POINTS = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic                 err;
      logic                 last;
      logic [1:0]           quad;
   } item_flags_type;

   function automatic logic signed [ZBits-1:0] atan_turn(input int k);
      logic signed [ZBits-1:0] v;
      begin
         case (k)
            0: v = 33'sd536870912;   1: v = 33'sd316933406;
            2: v = 33'sd167458907;   3: v = 33'sd85004756;
            4: v = 33'sd42667331;    5: v = 33'sd21354465;
            6: v = 33'sd10679838;    7: v = 33'sd5340245;
            8: v = 33'sd2670163;     9: v = 33'sd1335087;
            10: v = 33'sd667544;     11: v = 33'sd333772;
            12: v = 33'sd166886;     13: v = 33'sd83443;
            14: v = 33'sd41722;      15: v = 33'sd20861;
            16: v = 33'sd10430;      17: v = 33'sd5215;
            18: v = 33'sd2608;       19: v = 33'sd1304;
            20: v = 33'sd652;        21: v = 33'sd326;
            22: v = 33'sd163;        default: v = 33'sd81;
         endcase
         return v;
      end
   endfunction

endpackage

// ===== design/circle_outline_point_generator_top.sv =====
// circle outline point generator: top level, csr port, divider, scaling
// depends on cop_pkg and cop_cordic
//
// channel   direction  signals
// req_      in         req_valid req_ready req_point_index
// rsp_      out        rsp_valid rsp_ready rsp_point_x rsp_point_y rsp_is_last rsp_index_error
// csr_      apb        psel penable pwrite paddr pwdata prdata pready
//
// one point per cycle when the output is not stalled; each input transfer passes through
// 13 register stages (4 divider, 6 cordic, 2 scale, output register with centre sum) before its result is offered.
// the pipeline moves as a whole when the output register is free or being taken.
// reset clears valid bits and the centre and radius registers, and sets the point count to 1.
module circle_outline_point_generator_top import cop_pkg::*; #(
   parameter int ANGLE_BITS = AngleBitsDefault,
   parameter int COORD_BITS = CoordBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [IndexBits-1:0]   req_point_index,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [OutBits-1:0] rsp_point_x,
   output logic signed [OutBits-1:0] rsp_point_y,
   output logic                   rsp_is_last,
   output logic                   rsp_index_error,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CsrAddrBits-1:0] csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam int NumLen = IndexBits + ANGLE_BITS;
   localparam int BitsPerDiv = (NumLen + DivSteps - 1) / DivSteps;

   logic [COORD_BITS-1:0] cx_ff, cy_ff;
   logic [RadiusBits-1:0] rad_ff;
   logic [NumBits-1:0]    num_ff;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0; cy_ff <= '0; rad_ff <= '0; num_ff <= NumBits'(1);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'b00) begin
         case (csr_reg_type'(csr_paddr[3:2]))
            REG_CENTER_X:   cx_ff  <= csr_pwdata[COORD_BITS-1:0];
            REG_CENTER_Y:   cy_ff  <= csr_pwdata[COORD_BITS-1:0];
            REG_RADIUS:     rad_ff <= csr_pwdata[RadiusBits-1:0];
            REG_NUM_POINTS: num_ff <= csr_pwdata[NumBits-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg_type'(csr_paddr[3:2]))
         REG_CENTER_X:   csr_prdata = 32'(cx_ff);
         REG_CENTER_Y:   csr_prdata = 32'(cy_ff);
         REG_RADIUS:     csr_prdata = 32'(rad_ff);
         REG_NUM_POINTS: csr_prdata = 32'(num_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // output register and stall
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // restoring divider, BitsPerDiv quotient bits per stage
   logic                  dv_ff  [DivSteps];
   logic [NumLen-1:0]     dn_ff  [DivSteps];
   logic [NumBits:0]      dr_ff  [DivSteps];
   item_flags_type        df_ff  [DivSteps];

   always_ff @(posedge clock) begin
      for (int s = 0; s < DivSteps; s++) begin
         if (reset) begin
            dv_ff[s] <= 1'b0;
         end else if (advance) begin
            dv_ff[s] <= (s == 0) ? (req_valid && req_ready) : dv_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [NumLen-1:0] n;
      logic [NumBits:0]  r;
      logic [NumBits+1:0] t;
      if (advance) begin
         for (int s = 0; s < DivSteps; s++) begin
            if (s == 0) begin
               n = {req_point_index, ANGLE_BITS'(0)};
               r = '0;
               df_ff[s].err  <= ({1'b0, req_point_index} >= {1'b0, num_ff});
               df_ff[s].last <= ({1'b0, req_point_index} == {1'b0, num_ff} - 17'd1);
               df_ff[s].quad <= 2'd0;
            end else begin
               n = dn_ff[s-1];
               r = dr_ff[s-1];
               df_ff[s] <= df_ff[s-1];
            end
            for (int j = 0; j < BitsPerDiv; j++) begin
               if (s*BitsPerDiv + j < NumLen) begin
                  t = {r, n[NumLen-1]};
                  n = {n[NumLen-2:0], 1'b0};
                  if (t >= {2'b00, num_ff}) begin
                     t = t - {2'b00, num_ff};
                     n[0] = 1'b1;
                  end
                  r = t[NumBits:0];
               end
            end
            dn_ff[s] <= n;
            dr_ff[s] <= r;
         end
      end
   end

   localparam int LD = DivSteps - 1;
   logic [ANGLE_BITS-1:0] angle;
   item_flags_type        cf_in;
   assign angle = dn_ff[LD][ANGLE_BITS-1:0];
   always_comb begin
      cf_in      = df_ff[LD];
      cf_in.quad = angle[ANGLE_BITS-1:ANGLE_BITS-2];
   end

   logic                        cv;
   logic signed [TrigBits-1:0]  cos_w, sin_w;
   item_flags_type              cf;

   cop_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
      .clock, .reset, .advance,
      .in_valid(dv_ff[LD]), .in_angle(angle), .in_flags(cf_in),
      .out_valid(cv), .out_cos(cos_w), .out_sin(sin_w), .out_flags(cf)
   );

   // scale: product, then truncate toward zero, then add centre
   logic                          mv_ff, sv_ff;
   logic signed [TrigBits+RadiusBits:0] px_ff, py_ff;
   item_flags_type                mf_ff, sf_ff;
   logic signed [OutBits-1:0]     sx_ff, sy_ff;

   function automatic logic signed [OutBits-1:0] trunc15(
      input logic signed [TrigBits+RadiusBits:0] p);
      logic signed [TrigBits+RadiusBits:0] a;
      begin
         a = p[TrigBits+RadiusBits] ? -p : p;
         a = a >>> 15;
         return OutBits'(p[TrigBits+RadiusBits] ? -a : a);
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0; sv_ff <= 1'b0; rsp_valid <= 1'b0;
      end else if (advance) begin
         mv_ff <= cv; sv_ff <= mv_ff; rsp_valid <= sv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff <= $signed({1'b0, rad_ff}) * cos_w;
         py_ff <= $signed({1'b0, rad_ff}) * sin_w;
         mf_ff <= cf;
         sx_ff <= trunc15(px_ff);
         sy_ff <= trunc15(py_ff);
         sf_ff <= mf_ff;
         rsp_point_x     <= sf_ff.err ? '0 : sx_ff + OutBits'(cx_ff);
         rsp_point_y     <= sf_ff.err ? '0 : sy_ff + OutBits'(cy_ff);
         rsp_is_last     <= sf_ff.last && !sf_ff.err;
         rsp_index_error <= sf_ff.err;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_point_x))
      else $error("result dropped under stall");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_last && rsp_index_error))
      else $error("last and error together");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("stalled with empty output");

endmodule

// ===== design/cop_cordic.sv =====
// circle outline point generator: pipelined rotation cordic, quadrant fold
// depends on cop_pkg
module cop_cordic import cop_pkg::*; #(
   parameter int ANGLE_BITS = AngleBitsDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  logic [ANGLE_BITS-1:0]      in_angle,
   input  item_flags_type             in_flags,
   output logic                       out_valid,
   output logic signed [TrigBits-1:0] out_cos,
   output logic signed [TrigBits-1:0] out_sin,
   output item_flags_type             out_flags
);

   logic                        vld_ff   [CordicStages];
   logic signed [CordicBits-1:0] x_ff    [CordicStages];
   logic signed [CordicBits-1:0] y_ff    [CordicStages];
   logic signed [ZBits-1:0]     z_ff     [CordicStages];
   item_flags_type              flg_ff   [CordicStages];

   logic signed [ZBits-1:0] z_start;
   assign z_start = ZBits'({in_angle[ANGLE_BITS-3:0], (32-ANGLE_BITS)'(0)});

   always_ff @(posedge clock) begin
      for (int s = 0; s < CordicStages; s++) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (advance) begin
            vld_ff[s] <= (s == 0) ? in_valid : vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      logic signed [CordicBits-1:0] x, y, nx, ny;
      logic signed [ZBits-1:0] z;
      if (advance) begin
         for (int s = 0; s < CordicStages; s++) begin
            if (s == 0) begin
               x = CordicGain; y = '0; z = z_start;
               flg_ff[s]  <= in_flags;
            end else begin
               x = x_ff[s-1]; y = y_ff[s-1]; z = z_ff[s-1];
               flg_ff[s]  <= flg_ff[s-1];
            end
            for (int j = 0; j < CordicPerStage; j++) begin
               if (!z[ZBits-1]) begin
                  nx = x - (y >>> (s*CordicPerStage+j));
                  ny = y + (x >>> (s*CordicPerStage+j));
                  z  = z - atan_turn(s*CordicPerStage+j);
               end else begin
                  nx = x + (y >>> (s*CordicPerStage+j));
                  ny = y - (x >>> (s*CordicPerStage+j));
                  z  = z + atan_turn(s*CordicPerStage+j);
               end
               x = nx; y = ny;
            end
            x_ff[s] <= x; y_ff[s] <= y; z_ff[s] <= z;
         end
      end
   end

   localparam int L = CordicStages - 1;
   logic signed [CordicBits-1:0] rx, ry;
   logic signed [TrigBits-1:0] rc, rs;
   assign rx = x_ff[L] + CordicBits'(1 << 14);
   assign ry = y_ff[L] + CordicBits'(1 << 14);
   assign rc = TrigBits'(rx >>> 15);
   assign rs = TrigBits'(ry >>> 15);

   always_comb begin
      case (flg_ff[L].quad)
         2'd0: begin out_cos = rc;  out_sin = rs;  end
         2'd1: begin out_cos = -rs; out_sin = rc;  end
         2'd2: begin out_cos = -rc; out_sin = -rs; end
         default: begin out_cos = rs; out_sin = -rc; end
      endcase
   end

   assign out_valid = vld_ff[L];
   assign out_flags = flg_ff[L];

endmodule
